>>> rtl/pce_pkg.sv
// Shared types and constants for the parametric CRC engine.
// Used by every module under rtl; no dependencies of its own.
package pce_pkg;

   // Configuration register indexes on the write channel
   typedef enum logic [2:0] {
      CSR_CRC_WIDTH      = 3'd0,
      CSR_POLYNOMIAL     = 3'd1,
      CSR_INITIAL_VALUE  = 3'd2,
      CSR_REFLECT_INPUT  = 3'd3,
      CSR_REFLECT_OUTPUT = 3'd4,
      CSR_FINAL_XOR      = 3'd5
   } csr_index_type;

   // Reset settings: CRC-32
   localparam logic [6:0]  RESET_CRC_WIDTH      = 7'd32;
   localparam logic [63:0] RESET_POLYNOMIAL     = 64'h0000_0000_04C1_1DB7;
   localparam logic [63:0] RESET_INITIAL_VALUE  = 64'h0000_0000_FFFF_FFFF;
   localparam logic        RESET_REFLECT_INPUT  = 1'b1;
   localparam logic        RESET_REFLECT_OUTPUT = 1'b1;
   localparam logic [63:0] RESET_FINAL_XOR      = 64'h0000_0000_FFFF_FFFF;

   // Smallest CRC width the engine runs at
   localparam logic [6:0]  MIN_CRC_WIDTH = 7'd8;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   // Live configuration handed from front to back
   typedef struct packed {
      logic [6:0]  crc_width;
      logic [63:0] polynomial;
      logic [63:0] initial_value;
      logic        reflect_input;
      logic        reflect_output;
      logic [63:0] final_xor;
   } cfg_type;

   // One classified beat, byte already in MSB-first order
   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_data;
      logic       last;
   } item_type;

   // Queue status towards the front and back
   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

   function automatic logic [7:0] reverse_byte(input logic [7:0] value);
      logic [7:0] result;
      for (int i = 0; i < 8; i++) begin
         result[i] = value[7 - i];
      end
      return result;
   endfunction

endpackage

>>> rtl/pce_front.sv
// Front of the CRC engine: configuration registers and input beat classification.
// Depends on pce_pkg for the register indexes, reset values and item type.
module pce_front (
   input  logic                 clock,
   input  logic                 reset,
   // configuration write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [63:0]          csr_data,
   // input beat
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,
   input  logic                 req_tuser,
   input  logic                 req_tlast,
   // towards the queue and back
   input  pce_pkg::queue_status_type q_status,
   output logic                 q_push,
   output pce_pkg::item_type    q_item,
   output pce_pkg::cfg_type     cfg
);

   pce_pkg::cfg_type cfg_ff, cfg_in;

   // Take a register write on every valid beat
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pce_pkg::CSR_CRC_WIDTH:      cfg_in.crc_width      = csr_data[6:0];
            pce_pkg::CSR_POLYNOMIAL:     cfg_in.polynomial     = csr_data;
            pce_pkg::CSR_INITIAL_VALUE:  cfg_in.initial_value  = csr_data;
            pce_pkg::CSR_REFLECT_INPUT:  cfg_in.reflect_input  = csr_data[0];
            pce_pkg::CSR_REFLECT_OUTPUT: cfg_in.reflect_output = csr_data[0];
            pce_pkg::CSR_FINAL_XOR:      cfg_in.final_xor      = csr_data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.crc_width      <= pce_pkg::RESET_CRC_WIDTH;
         cfg_ff.polynomial     <= pce_pkg::RESET_POLYNOMIAL;
         cfg_ff.initial_value  <= pce_pkg::RESET_INITIAL_VALUE;
         cfg_ff.reflect_input  <= pce_pkg::RESET_REFLECT_INPUT;
         cfg_ff.reflect_output <= pce_pkg::RESET_REFLECT_OUTPUT;
         cfg_ff.final_xor      <= pce_pkg::RESET_FINAL_XOR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

   // Accept a beat whenever the queue has room
   assign req_tready = !q_status.full;
   assign q_push     = req_tvalid && req_tready;

   // Classify: put the byte in MSB-first order, keep the flags
   always_comb begin
      q_item.data_byte = cfg_ff.reflect_input ? pce_pkg::reverse_byte(req_tdata) : req_tdata;
      q_item.has_data  = req_tuser;
      q_item.last      = req_tlast;
   end

endmodule

>>> rtl/pce_fifo.sv
// Short queue of classified beats between the front and the back.
// Depends on pce_pkg for the item type and the queue depth.
module pce_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  pce_pkg::item_type         item_in,
   input  logic                      pop,
   output pce_pkg::item_type         item_out,
   output pce_pkg::queue_status_type status
);

   pce_pkg::item_type slot_ff [pce_pkg::QUEUE_DEPTH];
   logic [pce_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pce_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pce_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == pce_pkg::QUEUE_CNT_W'(pce_pkg::QUEUE_DEPTH));
   assign status.valid = (count_ff != '0);
   assign item_out     = slot_ff[rd_ptr_ff];

   // Advance pointers and the fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold beats in their slots; no reset on payload
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!status.full || pop))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> status.valid)
      else $error("queue read while empty");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("fill count missed a write");

endmodule

>>> rtl/pce_back.sv
// Back of the CRC engine: running register, eight shift steps, result register.
// Depends on pce_pkg for the item and configuration types.
module pce_back #(
   parameter int MAX_WIDTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  pce_pkg::cfg_type          cfg,
   input  pce_pkg::item_type         head,
   input  pce_pkg::queue_status_type q_status,
   output logic                      q_pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [63:0]               rsp_tdata
);

   localparam int SHW = $clog2(MAX_WIDTH);

   logic [MAX_WIDTH-1:0] crc_ff, crc_in;
   logic                 in_msg_ff, in_msg_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [MAX_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   logic [6:0]           eff_width;
   logic [SHW-1:0]       shift;
   logic [MAX_WIDTH-1:0] mask;
   logic [MAX_WIDTH-1:0] poly_al;
   logic [MAX_WIDTH-1:0] base;
   logic [MAX_WIDTH-1:0] stepped;
   logic [MAX_WIDTH-1:0] reversed;
   logic [MAX_WIDTH-1:0] result;

   // Clamp the width and derive the top-alignment shift
   always_comb begin
      if (cfg.crc_width < pce_pkg::MIN_CRC_WIDTH) begin
         eff_width = pce_pkg::MIN_CRC_WIDTH;
      end else if (cfg.crc_width > 7'(MAX_WIDTH)) begin
         eff_width = 7'(MAX_WIDTH);
      end else begin
         eff_width = cfg.crc_width;
      end
      shift   = SHW'(7'(MAX_WIDTH) - eff_width);
      mask    = {MAX_WIDTH{1'b1}} >> shift;
      poly_al = cfg.polynomial[MAX_WIDTH-1:0] << shift;
   end

   // Align the register to the top; for a beat with data, fold in the byte and run eight shift steps
   always_comb begin
      logic [MAX_WIDTH-1:0] acc;
      base = in_msg_ff ? crc_ff : cfg.initial_value[MAX_WIDTH-1:0];
      acc  = base << shift;
      if (head.has_data) begin
         acc[MAX_WIDTH-1 -: 8] = acc[MAX_WIDTH-1 -: 8] ^ head.data_byte;
         for (int k = 0; k < 8; k++) begin
            acc = acc[MAX_WIDTH-1] ? ((acc << 1) ^ poly_al) : (acc << 1);
         end
      end
      stepped = acc;
   end

   // Reflect over the full word: the top-aligned value lands reflected at the bottom
   always_comb begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
         reversed[i] = stepped[MAX_WIDTH-1-i];
      end
      result = ((cfg.reflect_output ? reversed : (stepped >> shift))
                ^ cfg.final_xor[MAX_WIDTH-1:0]) & mask;
   end

   // Pop unless a closing beat would overwrite a waiting result
   assign q_pop = q_status.valid && (!head.last || !rsp_valid_ff || rsp_tready);

   always_comb begin
      crc_in       = crc_ff;
      in_msg_in    = in_msg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (q_pop) begin
         crc_in    = stepped >> shift;
         in_msg_in = !head.last;
         if (head.last) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= '0;
         in_msg_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         in_msg_ff    <= in_msg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 64'(rsp_data_ff);

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (q_pop && head.last) |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before it was taken");

   a_close_message: assert property (@(posedge clock) disable iff (reset)
      (q_pop && head.last) |=> (!in_msg_ff && rsp_valid_ff))
      else $error("closing beat did not end the message");

   a_open_message: assert property (@(posedge clock) disable iff (reset)
      (q_pop && !head.last) |=> in_msg_ff)
      else $error("beat without last left no message open");

   a_result_masked: assert property (@(posedge clock) disable iff (reset)
      (q_pop && head.last) |=> ((rsp_data_ff & ~$past(mask)) == '0))
      else $error("result has bits above the CRC width");

endmodule

>>> rtl/parametric_crc_engine.sv
// Top level of the parametric CRC engine: front, beat queue and back.
// Depends on pce_pkg, pce_front, pce_fifo and pce_back.
//
//   channel   direction  payload (low bit first)                     handshake
//   req_      in         tdata: data_byte[7:0]; tuser: has_data;      tvalid/tready
//                        tlast: last
//   rsp_      out        tdata: crc_result[63:0]                      tvalid/tready
//   csr_      in         index[2:0]: register, data[63:0]: value      valid/ready
//
// One beat a cycle sustained unless a closing beat waits on an untaken result;
// the eight polynomial steps are combinational in the back. A closing beat is
// written into the queue; the back then updates the CRC register and loads the
// result register. Reset clears the control state; settings return to CRC-32.
// A stalled result holds the back only for a closing beat; the two-entry queue
// keeps the input side taking beats until it is full. csr_ready is always high.
module parametric_crc_engine #(
   parameter int MAX_WIDTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte[7:0]
   input  logic        req_tuser,   // has_data
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // crc_result[63:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   pce_pkg::cfg_type          cfg;
   pce_pkg::item_type         q_item;
   pce_pkg::item_type         head;
   pce_pkg::queue_status_type q_status;
   logic                      q_push;
   logic                      q_pop;

   pce_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_item     (q_item),
      .cfg        (cfg)
   );

   pce_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .item_in  (q_item),
      .pop      (q_pop),
      .item_out (head),
      .status   (q_status)
   );

   pce_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head       (head),
      .q_status   (q_status),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
